// ===== hw/rtl/tgc_pkg.sv =====
// Shared types, widths and codes for the touch gesture classifier.
`default_nettype none

package tgc_pkg;

   localparam int ACTION_W    = 3;
   localparam int POS_W       = 12;
   localparam int GESTURE_W   = 3;
   localparam int THRESH_W    = 12;
   localparam int WINDOW_W    = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // input word actions
   localparam logic [ACTION_W-1:0] ACT_POS_X = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_POS_Y = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_DOWN  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_UP    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd4;

   // result word gestures
   localparam logic [GESTURE_W-1:0] GEST_NONE       = 3'd0;
   localparam logic [GESTURE_W-1:0] GEST_SWIPE_DOWN = 3'd1;
   localparam logic [GESTURE_W-1:0] GEST_SWIPE_UP   = 3'd2;
   localparam logic [GESTURE_W-1:0] GEST_TAP        = 3'd3;
   localparam logic [GESTURE_W-1:0] GEST_DOUBLE_TAP = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SWIPE_THRESHOLD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_THRESHOLD     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOUBLE_TAP_WINDOW = 2'd2;

   localparam logic [THRESH_W-1:0] SWIPE_THRESHOLD_RST   = 12'd30;
   localparam logic [THRESH_W-1:0] TAP_THRESHOLD_RST     = 12'd30;
   localparam logic [WINDOW_W-1:0] DOUBLE_TAP_WINDOW_RST = 16'd400;

   typedef struct packed {
      logic [THRESH_W-1:0] swipe_threshold;
      logic [THRESH_W-1:0] tap_threshold;
      logic [WINDOW_W-1:0] double_tap_window;
   } tgc_cfg_type;

   typedef struct packed {
      logic [GESTURE_W-1:0] gesture;
      logic [POS_W-1:0]     where_x;
      logic [POS_W-1:0]     where_y;
   } tgc_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tgc_if.sv =====
// Channel interfaces: request, response and register write.
`default_nettype none

interface tgc_req_if import tgc_pkg::*;;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [POS_W-1:0]    position;

   modport source (output valid, output action, output position, input ready);
   modport sink   (input valid, input action, input position, output ready);
endinterface

interface tgc_rsp_if import tgc_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [GESTURE_W-1:0] gesture;
   logic [POS_W-1:0]     where_x;
   logic [POS_W-1:0]     where_y;

   modport source (output valid, output gesture, output where_x, output where_y,
                   input ready);
   modport sink   (input valid, input gesture, input where_x, input where_y,
                   output ready);
endinterface

interface tgc_csr_if import tgc_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tgc_engine.sv =====
// Gesture state registers and single-pass classify logic.
`default_nettype none

module tgc_engine
   import tgc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [ACTION_W-1:0] action,
   input  logic [POS_W-1:0]    position,
   input  tgc_cfg_type         cfg,
   output tgc_result_type      result
);

   logic [POS_W-1:0]    cur_x_ff, cur_x_in;
   logic                cur_x_valid_ff, cur_x_valid_in;
   logic [POS_W-1:0]    cur_y_ff, cur_y_in;
   logic                cur_y_valid_ff, cur_y_valid_in;
   logic [POS_W-1:0]    start_x_ff, start_x_in;
   logic [POS_W-1:0]    start_y_ff, start_y_in;
   logic                start_valid_ff, start_valid_in;
   logic                touching_ff, touching_in;
   logic                last_tap_valid_ff, last_tap_valid_in;
   logic [WINDOW_W-1:0] since_ff, since_in;

   logic [POS_W-1:0] dx;
   logic [POS_W-1:0] dy;
   logic             in_window;

   assign dx = (cur_x_ff > start_x_ff) ? cur_x_ff - start_x_ff : start_x_ff - cur_x_ff;
   assign dy = (cur_y_ff > start_y_ff) ? cur_y_ff - start_y_ff : start_y_ff - cur_y_ff;
   assign in_window = since_ff < cfg.double_tap_window;

   always_comb begin
      cur_x_in          = cur_x_ff;
      cur_x_valid_in    = cur_x_valid_ff;
      cur_y_in          = cur_y_ff;
      cur_y_valid_in    = cur_y_valid_ff;
      start_x_in        = start_x_ff;
      start_y_in        = start_y_ff;
      start_valid_in    = start_valid_ff;
      touching_in       = touching_ff;
      last_tap_valid_in = last_tap_valid_ff;
      since_in          = since_ff;
      result            = '0;

      unique case (action)
         ACT_POS_X: begin
            cur_x_in       = position;
            cur_x_valid_in = 1'b1;
            // start point fixed the first time both coordinates are known
            if (touching_ff && !start_valid_ff && cur_y_valid_ff) begin
               start_x_in     = position;
               start_y_in     = cur_y_ff;
               start_valid_in = 1'b1;
            end
         end
         ACT_POS_Y: begin
            cur_y_in       = position;
            cur_y_valid_in = 1'b1;
            if (touching_ff && !start_valid_ff && cur_x_valid_ff) begin
               start_x_in     = cur_x_ff;
               start_y_in     = position;
               start_valid_in = 1'b1;
            end
         end
         ACT_DOWN: begin
            touching_in    = 1'b1;
            start_valid_in = 1'b0;
         end
         ACT_UP: begin
            if (touching_ff) begin
               touching_in = 1'b0;
               if (cur_x_valid_ff && cur_y_valid_ff && start_valid_ff) begin
                  if (dy > cfg.swipe_threshold) begin
                     result.gesture = (cur_y_ff > start_y_ff) ? GEST_SWIPE_DOWN
                                                                : GEST_SWIPE_UP;
                     last_tap_valid_in = 1'b0;
                  end else if (dx < cfg.tap_threshold && dy < cfg.tap_threshold) begin
                     result.where_x = cur_x_ff;
                     result.where_y = cur_y_ff;
                     if (last_tap_valid_ff && in_window) begin
                        result.gesture    = GEST_DOUBLE_TAP;
                        last_tap_valid_in = 1'b0;
                     end else begin
                        result.gesture    = GEST_TAP;
                        last_tap_valid_in = 1'b1;
                        since_in          = '0;
                     end
                  end
               end
               cur_x_valid_in = 1'b0;
               cur_y_valid_in = 1'b0;
               start_valid_in = 1'b0;
            end
         end
         ACT_TICK: begin
            // saturates at the window; cannot wrap since since_ff < window
            if (in_window) begin
               since_in = since_ff + WINDOW_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff          <= '0;
         cur_x_valid_ff    <= 1'b0;
         cur_y_ff          <= '0;
         cur_y_valid_ff    <= 1'b0;
         start_x_ff        <= '0;
         start_y_ff        <= '0;
         start_valid_ff    <= 1'b0;
         touching_ff       <= 1'b0;
         last_tap_valid_ff <= 1'b0;
         since_ff          <= '0;
      end else if (step) begin
         cur_x_ff          <= cur_x_in;
         cur_x_valid_ff    <= cur_x_valid_in;
         cur_y_ff          <= cur_y_in;
         cur_y_valid_ff    <= cur_y_valid_in;
         start_x_ff        <= start_x_in;
         start_y_ff        <= start_y_in;
         start_valid_ff    <= start_valid_in;
         touching_ff       <= touching_in;
         last_tap_valid_ff <= last_tap_valid_in;
         since_ff          <= since_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/touch_gesture_classifier_unit.sv =====
// Top level of the touch gesture classifier: channels, registers, pipeline.
`default_nettype none

// Touch gesture classifier. Takes one event word per cycle on req_bus (x or y
// position, finger down, finger up, 1 ms tick) and returns exactly one word
// per event on rsp_bus: gesture none, swipe down, swipe up, tap or double tap,
// with the tap position for taps. Each event passes an input register,
// compare logic that also updates the touch state, and a result register
// that drives rsp valid; the sustained rate is one event per cycle while
// rsp_bus is not stalling; rsp back-pressure stalls the input register only
// when both stages are full. Registers (csr_bus, index 0..2):
// swipe threshold, tap threshold, double-tap window in ticks. Writes are
// always taken (csr ready is tied high) and are meant to happen while the
// block is idle; index 3 is ignored.
module touch_gesture_classifier_unit
   import tgc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   tgc_req_if.sink    req_bus,
   tgc_rsp_if.source  rsp_bus,
   tgc_csr_if.sink    csr_bus
);

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [ACTION_W-1:0] in_action_ff;
   logic [POS_W-1:0]    in_position_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   tgc_result_type      rsp_word_ff;

   tgc_cfg_type         cfg_ff;
   tgc_result_type      result;

   logic advance;
   logic req_take;

   // input word moves into the result register when there is room
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff   <= req_bus.action;
         in_position_ff <= req_bus.position;
      end
      if (advance) begin
         rsp_word_ff <= result;
      end
   end

   // register file
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swipe_threshold   <= SWIPE_THRESHOLD_RST;
         cfg_ff.tap_threshold     <= TAP_THRESHOLD_RST;
         cfg_ff.double_tap_window <= DOUBLE_TAP_WINDOW_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_SWIPE_THRESHOLD:   cfg_ff.swipe_threshold   <= csr_bus.data[THRESH_W-1:0];
            CSR_TAP_THRESHOLD:     cfg_ff.tap_threshold     <= csr_bus.data[THRESH_W-1:0];
            CSR_DOUBLE_TAP_WINDOW: cfg_ff.double_tap_window <= csr_bus.data[WINDOW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tgc_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .action   (in_action_ff),
      .position (in_position_ff),
      .cfg      (cfg_ff),
      .result   (result)
   );

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.gesture = rsp_word_ff.gesture;
   assign rsp_bus.where_x = rsp_word_ff.where_x;
   assign rsp_bus.where_y = rsp_word_ff.where_y;

endmodule

`default_nettype wire

// ===== hw/rtl/tgc_checker.sv =====
// Port-level checks for the touch gesture classifier, bound to the top level.
`default_nettype none

module tgc_checker
   import tgc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [GESTURE_W-1:0] rsp_gesture,
   input logic [POS_W-1:0]     rsp_where_x,
   input logic [POS_W-1:0]     rsp_where_y
);

   // no response word appears right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // only taps carry a position
   a_pos_only_for_taps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_gesture != GEST_TAP && rsp_gesture != GEST_DOUBLE_TAP)
      |-> (rsp_where_x == '0 && rsp_where_y == '0))
      else $error("position on non-tap gesture");

   a_gesture_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gesture == GEST_NONE || rsp_gesture == GEST_SWIPE_DOWN ||
                     rsp_gesture == GEST_SWIPE_UP || rsp_gesture == GEST_TAP ||
                     rsp_gesture == GEST_DOUBLE_TAP))
      else $error("gesture code out of range");

   // an idle output side never blocks the input
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && $past(!req_valid || !req_ready) && !$past(reset)) |-> req_ready)
      else $error("input stalled with empty pipeline");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_gesture) &&
                                    $stable(rsp_where_x) && $stable(rsp_where_y)))
      else $error("stalled response word changed");

endmodule

bind touch_gesture_classifier_unit tgc_checker u_tgc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_gesture (rsp_bus.gesture),
   .rsp_where_x (rsp_bus.where_x),
   .rsp_where_y (rsp_bus.where_y)
);

`default_nettype wire
